[hw/rtl/ppap_pkg.sv]
// Shared types and constants for the ping-pong PWM audio player.
package ppap_pkg;

    // Sample store geometry.
    localparam int BANK_BYTES = 512;
    localparam int BANK_AW    = $clog2(BANK_BYTES);
    localparam int MEM_DEPTH  = 2 * BANK_BYTES;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);

    // Field widths.
    localparam int KIND_W     = 2;
    localparam int WIDX_W     = 9;
    localparam int BYTE_W     = 8;
    localparam int DUTY_W     = 9;
    localparam int REMAIN_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Word kinds.
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGN_FIX        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_SKIP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_PLAY_BYTES = 3'd4;

    // Reset values and fixed numbers.
    localparam logic [REMAIN_W-1:0] RESET_PLAY_BYTES = 10'd512;
    localparam logic [DUTY_W-1:0]   DUTY_OFFSET      = 9'd30;

    // Per-word information handed from playback control to the duty stage.
    typedef struct packed {
        logic              updated;
        logic              stereo;
        logic [BYTE_W-1:0] sign_fix;
        logic              empty;
        logic              bank;
    } t_item_info;

endpackage

[hw/rtl/ppap_in_if.sv]
// Input channel: valid/ready handshake carrying one command word.
interface ppap_in_if;
    logic                         valid;
    logic                         ready;
    logic [ppap_pkg::KIND_W-1:0]  kind;
    logic                         write_bank;
    logic [ppap_pkg::WIDX_W-1:0]  write_index;
    logic [ppap_pkg::BYTE_W-1:0]  write_byte;

    modport source (output valid, output kind, output write_bank, output write_index,
                    output write_byte, input ready);
    modport sink   (input valid, input kind, input write_bank, input write_index,
                    input write_byte, output ready);
endinterface

[hw/rtl/ppap_out_if.sv]
// Output channel: valid/ready handshake carrying one result word.
interface ppap_out_if;
    logic                         valid;
    logic                         ready;
    logic [ppap_pkg::DUTY_W-1:0]  left_duty;
    logic [ppap_pkg::DUTY_W-1:0]  right_duty;
    logic                         duty_updated;
    logic                         bank_empty;
    logic                         active_bank;

    modport source (output valid, output left_duty, output right_duty, output duty_updated,
                    output bank_empty, output active_bank, input ready);
    modport sink   (input valid, input left_duty, input right_duty, input duty_updated,
                    input bank_empty, input active_bank, output ready);
endinterface

[hw/rtl/ppap_sample_ram.sv]
// Two-bank sample store: one write port and two registered read ports.
module ppap_sample_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ppap_pkg::MEM_AW-1:0] i_waddr,
    input  logic [ppap_pkg::BYTE_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [ppap_pkg::MEM_AW-1:0] i_raddr_a,
    input  logic [ppap_pkg::MEM_AW-1:0] i_raddr_b,
    output logic [ppap_pkg::BYTE_W-1:0] o_rdata_a,
    output logic [ppap_pkg::BYTE_W-1:0] o_rdata_b
);
    import ppap_pkg::*;

    logic [BYTE_W-1:0] r_mem [MEM_DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

[hw/rtl/ppap_play_ctrl.sv]
// Configuration registers, skip divider, play pointer and bank swap control.
module ppap_play_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ppap_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppap_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_take,
    input  logic [ppap_pkg::KIND_W-1:0]     i_kind,
    input  logic                            i_write_bank,
    input  logic [ppap_pkg::WIDX_W-1:0]     i_write_index,
    input  logic [ppap_pkg::BYTE_W-1:0]     i_write_byte,
    output logic                            o_mem_we,
    output logic [ppap_pkg::MEM_AW-1:0]     o_mem_waddr,
    output logic [ppap_pkg::BYTE_W-1:0]     o_mem_wdata,
    output logic [ppap_pkg::MEM_AW-1:0]     o_rd_addr_l,
    output logic [ppap_pkg::MEM_AW-1:0]     o_rd_addr_r,
    output ppap_pkg::t_item_info            o_info
);
    import ppap_pkg::*;

    localparam logic [BANK_AW:0]   BANK_LIMIT = (BANK_AW + 1)'(BANK_BYTES);
    localparam logic [MEM_AW-1:0]  BANK_BASE  = MEM_AW'(BANK_BYTES);

    // Configuration registers.
    logic [1:0]          r_channel_count;
    logic [1:0]          r_sample_bytes;
    logic [BYTE_W-1:0]   r_sign_fix;
    logic [7:0]          r_tick_skip;
    logic [REMAIN_W-1:0] r_bank_play_bytes;

    // Playback state.
    logic [7:0]          r_skip, n_skip;
    logic [BANK_AW-1:0]  r_pos, n_pos;
    logic [REMAIN_W-1:0] r_rem, n_rem;
    logic                r_bank, n_bank;
    logic                r_empty, n_empty;

    logic [1:0]          size;
    logic                stereo;
    logic [2:0]          stride;
    logic [7:0]          eff_skip;
    logic [7:0]          skip_dec;
    logic                expire;
    logic                last_chunk;
    logic [BANK_AW:0]    right_sum;
    logic [BANK_AW:0]    next_sum;
    logic [BANK_AW-1:0]  right_pos;
    logic [BANK_AW-1:0]  next_pos;
    logic [BANK_AW-1:0]  first_pos;
    logic [MEM_AW-1:0]   play_base;

    // Effective sample format and divider settings.
    assign size     = r_sample_bytes[1] ? 2'd2 : 2'd1;
    assign stereo   = (r_channel_count == 2'd2);
    assign stride   = stereo ? {size, 1'b0} : {1'b0, size};
    assign eff_skip = (r_tick_skip == 8'd0) ? 8'd1 : r_tick_skip;
    assign skip_dec = r_skip - 8'd1;
    assign expire   = (i_kind == KIND_TICK) && (skip_dec == 8'd0);

    // Positions wrap within the playing bank.
    assign right_sum  = {1'b0, r_pos} + (BANK_AW + 1)'(size);
    assign next_sum   = {1'b0, r_pos} + (BANK_AW + 1)'(stride);
    assign right_pos  = (right_sum >= BANK_LIMIT) ? BANK_AW'(right_sum - BANK_LIMIT)
                                                  : BANK_AW'(right_sum);
    assign next_pos   = (next_sum >= BANK_LIMIT) ? BANK_AW'(next_sum - BANK_LIMIT)
                                                 : BANK_AW'(next_sum);
    assign first_pos  = BANK_AW'(size - 2'd1);
    assign last_chunk = (r_rem <= REMAIN_W'(stride));

    // Sample reads for the left and right channels.
    assign play_base   = r_bank ? BANK_BASE : '0;
    assign o_rd_addr_l = play_base + MEM_AW'(r_pos);
    assign o_rd_addr_r = play_base + MEM_AW'(right_pos);

    // Byte writes land in either bank; indexes past the bank end are dropped.
    assign o_mem_we    = i_take && (i_kind == KIND_WRITE) &&
                         (int'(i_write_index) < BANK_BYTES);
    assign o_mem_waddr = (i_write_bank ? BANK_BASE : '0) + MEM_AW'(i_write_index);
    assign o_mem_wdata = i_write_byte;

    // Next playback state for the current word.
    always_comb begin
        n_skip  = r_skip;
        n_pos   = r_pos;
        n_rem   = r_rem;
        n_bank  = r_bank;
        n_empty = r_empty;
        case (i_kind)
            KIND_TICK: begin
                n_skip = skip_dec;
                if (expire) begin
                    n_skip = eff_skip;
                    if (last_chunk) begin
                        n_bank  = ~r_bank;
                        n_pos   = first_pos;
                        n_rem   = r_bank_play_bytes;
                        n_empty = 1'b1;
                    end else begin
                        n_pos = next_pos;
                        n_rem = r_rem - REMAIN_W'(stride);
                    end
                end
            end
            KIND_START: begin
                n_bank  = 1'b0;
                n_pos   = first_pos;
                n_rem   = r_bank_play_bytes;
                n_empty = 1'b0;
            end
            KIND_ACK: begin
                n_empty = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_info.updated  = expire;
    assign o_info.stereo   = stereo;
    assign o_info.sign_fix = r_sign_fix;
    assign o_info.empty    = n_empty;
    assign o_info.bank     = n_bank;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count   <= 2'd1;
            r_sample_bytes    <= 2'd1;
            r_sign_fix        <= '0;
            r_tick_skip       <= 8'd1;
            r_bank_play_bytes <= RESET_PLAY_BYTES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNEL_COUNT:   r_channel_count   <= i_cfg_data[1:0];
                CFG_SAMPLE_BYTES:    r_sample_bytes    <= i_cfg_data[1:0];
                CFG_SIGN_FIX:        r_sign_fix        <= i_cfg_data[BYTE_W-1:0];
                CFG_TICK_SKIP:       r_tick_skip       <= i_cfg_data[7:0];
                CFG_BANK_PLAY_BYTES: r_bank_play_bytes <= i_cfg_data[REMAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Playback state update on each accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip  <= 8'd1;
            r_pos   <= '0;
            r_rem   <= RESET_PLAY_BYTES;
            r_bank  <= 1'b0;
            r_empty <= 1'b0;
        end else if (i_take) begin
            r_skip  <= n_skip;
            r_pos   <= n_pos;
            r_rem   <= n_rem;
            r_bank  <= n_bank;
            r_empty <= n_empty;
        end
    end

endmodule

[hw/rtl/ppap_duty_stage.sv]
// Duty computation from the read sample bytes, duty registers and result register.
module ppap_duty_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  ppap_pkg::t_item_info        i_info,
    input  logic [ppap_pkg::BYTE_W-1:0] i_left_byte,
    input  logic [ppap_pkg::BYTE_W-1:0] i_right_byte,
    input  logic                        i_out_ready,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    output logic [ppap_pkg::DUTY_W-1:0] o_left_duty,
    output logic [ppap_pkg::DUTY_W-1:0] o_right_duty,
    output logic                        o_duty_updated,
    output logic                        o_bank_empty,
    output logic                        o_active_bank
);
    import ppap_pkg::*;

    logic              r_s1_valid;
    t_item_info        r_s1;
    logic [DUTY_W-1:0] r_left_duty;
    logic [DUTY_W-1:0] r_right_duty;
    logic              r_out_valid;
    logic [DUTY_W-1:0] r_out_left;
    logic [DUTY_W-1:0] r_out_right;
    logic              r_out_updated;
    logic              r_out_empty;
    logic              r_out_bank;

    logic              advance;
    logic [DUTY_W-1:0] left_new;
    logic [DUTY_W-1:0] right_new;
    logic [DUTY_W-1:0] n_left_duty;
    logic [DUTY_W-1:0] n_right_duty;

    // The result register moves when empty or taken; the read stage refills behind it.
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = advance || !r_s1_valid;

    // New duties: sign fix, then the fixed offset; mono copies the left duty.
    assign left_new     = DUTY_OFFSET + DUTY_W'(i_left_byte ^ r_s1.sign_fix);
    assign right_new    = r_s1.stereo ? DUTY_OFFSET + DUTY_W'(i_right_byte ^ r_s1.sign_fix)
                                      : left_new;
    assign n_left_duty  = r_s1.updated ? left_new : r_left_duty;
    assign n_right_duty = r_s1.updated ? right_new : r_right_duty;

    // Read stage: holds the word whose sample bytes are coming out of the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_take) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1 <= i_info;
        end
    end

    // Duty registers keep the last played sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_duty  <= '0;
            r_right_duty <= '0;
        end else if (advance && r_s1_valid) begin
            r_left_duty  <= n_left_duty;
            r_right_duty <= n_right_duty;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_left    <= n_left_duty;
            r_out_right   <= n_right_duty;
            r_out_updated <= r_s1.updated;
            r_out_empty   <= r_s1.empty;
            r_out_bank    <= r_s1.bank;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_duty    = r_out_left;
    assign o_right_duty   = r_out_right;
    assign o_duty_updated = r_out_updated;
    assign o_bank_empty   = r_out_empty;
    assign o_active_bank  = r_out_bank;

endmodule

[hw/rtl/ping_pong_pwm_audio_player_unit.sv]
// Top level of the ping-pong PWM audio player.
// The read stage registers each accepted word with its sample-store read; the result
// register loads from it when empty or taken. One word per cycle while results are taken.
// Reset (synchronous, active low) restores register defaults, the divider, play pointer,
// bank, empty flag and duties; the sample store is not cleared and needs no clearing pass.
module ping_pong_pwm_audio_player_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ppap_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ppap_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ppap_in_if.sink                         i_in,
    ppap_out_if.source                      o_out
);
    import ppap_pkg::*;

    logic              take;
    logic              in_ready;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [MEM_AW-1:0] rd_addr_l;
    logic [MEM_AW-1:0] rd_addr_r;
    logic [BYTE_W-1:0] rd_left;
    logic [BYTE_W-1:0] rd_right;
    t_item_info        info;

    // Input handshake.
    assign i_in.ready = in_ready;
    assign take       = i_in.valid && in_ready;

    // Playback control and configuration.
    ppap_play_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_take        (take),
        .i_kind        (i_in.kind),
        .i_write_bank  (i_in.write_bank),
        .i_write_index (i_in.write_index),
        .i_write_byte  (i_in.write_byte),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_rd_addr_l   (rd_addr_l),
        .o_rd_addr_r   (rd_addr_r),
        .o_info        (info)
    );

    // Sample store.
    ppap_sample_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (take),
        .i_raddr_a (rd_addr_l),
        .i_raddr_b (rd_addr_r),
        .o_rdata_a (rd_left),
        .o_rdata_b (rd_right)
    );

    // Duty computation and result register.
    ppap_duty_stage u_duty (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_info         (info),
        .i_left_byte    (rd_left),
        .i_right_byte   (rd_right),
        .i_out_ready    (o_out.ready),
        .o_in_ready     (in_ready),
        .o_out_valid    (o_out.valid),
        .o_left_duty    (o_out.left_duty),
        .o_right_duty   (o_out.right_duty),
        .o_duty_updated (o_out.duty_updated),
        .o_bank_empty   (o_out.bank_empty),
        .o_active_bank  (o_out.active_bank)
    );

`ifndef ASSERT_OFF
    // A freshly played sample always carries the duty offset.
    a_duty_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.duty_updated |->
            (o_out.left_duty >= DUTY_OFFSET && o_out.right_duty >= DUTY_OFFSET))
        else $error("played duty below offset");

    // The input stalls only while a result waits to be taken.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without output backpressure");

    // Nothing is presented right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");
`endif

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the ping-pong PWM audio player unit.
module tb_top;
    import ppap_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PERCENT = 21;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS  = 107;
    localparam int MAX_PRINTS   = 30;

    // One command word and one result word as the channels carry them.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              write_bank;
        logic [WIDX_W-1:0] write_index;
        logic [BYTE_W-1:0] write_byte;
    } t_cmd_word;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic              duty_updated;
        logic              bank_empty;
        logic              active_bank;
    } t_duty_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ppap_in_if  in_if ();
    ppap_out_if out_if ();

    ping_pong_pwm_audio_player_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #2 i_clk = ~i_clk;

    // Pending command words and the duty words they are expected to produce.
    t_cmd_word  word_q[$];
    t_duty_word duty_expect_q[$];

    // Player copy: register settings.
    logic [1:0]          cfg_channels;
    logic [1:0]          cfg_sample_bytes;
    logic [BYTE_W-1:0]   cfg_sign_fix;
    logic [7:0]          cfg_tick_skip;
    logic [REMAIN_W-1:0] cfg_play_bytes;

    // Player copy: playback state and sample store.
    logic [BYTE_W-1:0] sample_mem [0:1][0:BANK_BYTES-1];
    logic [7:0]        skip_left;
    int unsigned       play_pos;
    int                bytes_left;
    logic              play_bank;
    logic              empty_flag_m;
    logic [DUTY_W-1:0] left_duty_m;
    logic [DUTY_W-1:0] right_duty_m;

    // Run control and statistics.
    logic        steady    = 1'b0;
    logic        hold_go   = 1'b0;
    logic        sink_hold = 1'b0;
    int unsigned fail_count   = 0;
    int unsigned result_count = 0;
    int unsigned load_count   = 0;
    int unsigned swap_count   = 0;
    int unsigned setting_count = 0;
    int unsigned cycle_count  = 0;
    int unsigned kind_count [0:3] = '{0, 0, 0, 0};

    // Playback restarts on bank 0 at the high byte of the first sample.
    function automatic void restart_playback();
        play_bank    = 1'b0;
        play_pos     = cfg_sample_bytes[1] ? 1 : 0;
        empty_flag_m = 1'b0;
        bytes_left   = cfg_play_bytes;
    endfunction

    // Applies one command word to the player copy and returns the duty word it causes.
    function automatic t_duty_word player_step(input t_cmd_word w);
        t_duty_word  r;
        int unsigned chan_bytes;
        int unsigned stride;
        int unsigned pos;
        logic        stereo;
        r.duty_updated = 1'b0;
        case (w.kind)
            KIND_TICK: begin
                skip_left = skip_left - 8'd1;
                if (skip_left == 8'd0) begin
                    skip_left  = (cfg_tick_skip == 8'd0) ? 8'd1 : cfg_tick_skip;
                    chan_bytes = cfg_sample_bytes[1] ? 2 : 1;
                    stereo     = (cfg_channels == 2'd2);
                    stride     = stereo ? 2 * chan_bytes : chan_bytes;
                    pos        = play_pos % BANK_BYTES;
                    left_duty_m = DUTY_OFFSET + {1'b0, sample_mem[play_bank][pos] ^ cfg_sign_fix};
                    if (stereo) begin
                        right_duty_m = DUTY_OFFSET + {1'b0,
                            sample_mem[play_bank][(pos + chan_bytes) % BANK_BYTES] ^ cfg_sign_fix};
                    end else begin
                        right_duty_m = left_duty_m;
                    end
                    play_pos   = (pos + stride) % BANK_BYTES;
                    bytes_left = bytes_left - int'(stride);
                    // The bank is used up: swap and flag the idle bank for refilling.
                    if (bytes_left <= 0) begin
                        play_bank    = ~play_bank;
                        play_pos     = chan_bytes - 1;
                        bytes_left   = cfg_play_bytes;
                        empty_flag_m = 1'b1;
                        swap_count++;
                    end
                    r.duty_updated = 1'b1;
                end
            end
            KIND_WRITE: sample_mem[w.write_bank][w.write_index] = w.write_byte;
            KIND_START: restart_playback();
            default:    empty_flag_m = 1'b0;
        endcase
        r.left_duty   = left_duty_m;
        r.right_duty  = right_duty_m;
        r.bank_empty  = empty_flag_m;
        r.active_bank = play_bank;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        fail_count++;
        if (fail_count <= MAX_PRINTS) begin
            $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                     result_count, what, got, want);
        end
    endtask

    // Driver: offers queued words, predicting each one as it is accepted.
    always @(posedge i_clk) begin : drive_words
        t_cmd_word w;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                w = '{in_if.kind, in_if.write_bank, in_if.write_index, in_if.write_byte};
                duty_expect_q.push_back(player_step(w));
                kind_count[w.kind]++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (word_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
                    w = word_q.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.kind        <= w.kind;
                    in_if.write_bank  <= w.write_bank;
                    in_if.write_index <= w.write_index;
                    in_if.write_byte  <= w.write_byte;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted duty word against the oldest expectation.
    always @(posedge i_clk) begin : check_words
        t_duty_word want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (duty_expect_q.size() == 0) begin
                    report_mismatch("result with no word pending", 1, 0);
                end else begin
                    want = duty_expect_q.pop_front();
                    if (out_if.left_duty !== want.left_duty)
                        report_mismatch("left_duty", out_if.left_duty, want.left_duty);
                    if (out_if.right_duty !== want.right_duty)
                        report_mismatch("right_duty", out_if.right_duty, want.right_duty);
                    if (out_if.duty_updated !== want.duty_updated)
                        report_mismatch("duty_updated", out_if.duty_updated, want.duty_updated);
                    if (out_if.bank_empty !== want.bank_empty)
                        report_mismatch("bank_empty", out_if.bank_empty, want.bank_empty);
                    if (out_if.active_bank !== want.active_bank)
                        report_mismatch("active_bank", out_if.active_bank, want.active_bank);
                    if (want.duty_updated)
                        load_count++;
                end
                result_count++;
            end
            out_if.ready <= !sink_hold && (steady || $urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Receiver hold-off: stalls the output long enough for the block to back up.
    initial begin : receiver_hold
        while (!hold_go) @(posedge i_clk);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, duty_expect_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_word(input logic [KIND_W-1:0] kind, input logic bank,
                              input logic [WIDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        t_cmd_word w;
        w = '{kind, bank, idx, data};
        word_q.push_back(w);
    endtask

    // Waits until every queued word has been accepted and answered, then lets the pipe settle.
    task automatic wait_idle();
        while (!(word_q.size() == 0 && in_if.valid === 1'b0 && duty_expect_q.size() == 0))
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_CHANNEL_COUNT:   cfg_channels     = data[1:0];
            CFG_SAMPLE_BYTES:    cfg_sample_bytes = data[1:0];
            CFG_SIGN_FIX:        cfg_sign_fix     = data[BYTE_W-1:0];
            CFG_TICK_SKIP:       cfg_tick_skip    = data[7:0];
            CFG_BANK_PLAY_BYTES: cfg_play_bytes   = data[REMAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [1:0] chans, input logic [1:0] chan_bytes,
                                input logic [7:0] fix, input logic [7:0] skip,
                                input logic [9:0] reload);
        write_reg(CFG_CHANNEL_COUNT, chans);
        write_reg(CFG_SAMPLE_BYTES, chan_bytes);
        write_reg(CFG_SIGN_FIX, fix);
        write_reg(CFG_TICK_SKIP, skip);
        write_reg(CFG_BANK_PLAY_BYTES, reload);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        setting_count++;
    endtask

    // Stimulus: fill both banks, a directed pass, then random phases under varied settings.
    initial begin : stimulus
        logic [7:0]        first_bytes [0:1][0:7];
        logic [KIND_W-1:0] kind;
        int unsigned       roll;
        first_bytes = '{'{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA},
                        '{8'hFF, 8'h00, 8'h7F, 8'h80, 8'hAA, 8'h55, 8'hFE, 8'h01}};

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        in_if.valid       = 1'b0;
        in_if.kind        = KIND_TICK;
        in_if.write_bank  = 1'b0;
        in_if.write_index = '0;
        in_if.write_byte  = '0;
        out_if.ready      = 1'b0;

        // Player copy starts from the reset defaults.
        cfg_channels     = 2'd1;
        cfg_sample_bytes = 2'd1;
        cfg_sign_fix     = '0;
        cfg_tick_skip    = 8'd1;
        cfg_play_bytes   = RESET_PLAY_BYTES;
        skip_left        = 8'd1;
        left_duty_m      = '0;
        right_duty_m     = '0;
        restart_playback();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every sample byte is written before any tick can read it.
        for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < BANK_BYTES; i++) begin
                queue_word(KIND_WRITE, b[0], i[WIDX_W-1:0],
                           (i < 8) ? first_bytes[b][i] : 8'($urandom_range(255)));
            end
        end

        // Reset settings: mono, one byte, no sign fix, every tick plays.
        queue_word(KIND_TICK, 1'b0, '0, '0);
        queue_word(KIND_TICK, 1'b1, '1, '1);
        queue_word(KIND_TICK, 1'b0, '0, '0);
        queue_word(KIND_ACK, 1'b0, '0, '0);
        queue_word(KIND_START, 1'b0, '0, '0);
        queue_word(KIND_WRITE, 1'b1, 9'd511, 8'hFF);
        queue_word(KIND_WRITE, 1'b0, 9'd0, 8'h00);
        wait_idle();

        // Stereo two-byte samples, zero skip and zero reload: after the restart every load swaps banks.
        write_config(2'd2, 2'd2, 8'h80, 8'd0, 10'd0);
        queue_word(KIND_TICK, 1'b0, '0, '0);
        queue_word(KIND_TICK, 1'b0, '0, '0);
        queue_word(KIND_ACK, 1'b0, '0, '0);
        queue_word(KIND_TICK, 1'b0, '0, '0);
        queue_word(KIND_START, 1'b0, '0, '0);
        queue_word(KIND_TICK, 1'b0, '0, '0);
        wait_idle();

        // Odd channel count and odd sample size, longest reload.
        write_config(2'd3, 2'd3, 8'hFF, 8'd3, 10'd1023);
        repeat (4) queue_word(KIND_TICK, 1'b0, '0, '0);
        queue_word(KIND_ACK, 1'b0, '0, '0);
        wait_idle();

        // Zero channel count, zero sample size and the slowest divider.
        write_config(2'd0, 2'd0, 8'h55, 8'd255, 10'd1);
        repeat (3) queue_word(KIND_TICK, 1'b0, '0, '0);
        wait_idle();

        // Random phases, each under its own register setting.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: write_config(2'd2, 2'd1, 8'h00, 8'd1, 10'd40);
                1: write_config(2'd1, 2'd2, 8'h80, 8'd2, 10'd17);
                2: write_config(2'd2, 2'd2, 8'hFF, 8'd1, 10'd1023);
                3: write_config(2'd0, 2'd0, 8'($urandom_range(255)), 8'd0, 10'd0);
                4: write_config(2'd3, 2'd3, 8'h80, 8'd255, 10'd512);
                default: begin
                    roll = $urandom_range(2);
                    write_config(2'($urandom_range(3)), 2'($urandom_range(3)),
                                 (roll == 0) ? 8'h00 : (roll == 1) ? 8'h80
                                                                   : 8'($urandom_range(255)),
                                 8'($urandom_range(1, 6)),
                                 ($urandom_range(3) == 0) ? 10'd512
                                                          : 10'($urandom_range(1, 64)));
                end
            endcase
            if (p == 0)
                hold_go <= 1'b1;
            if (p == 2)
                steady <= 1'b1;
            // Mostly ticks, with writes refreshing samples and occasional acks and restarts.
            for (int n = 0; n < PHASE_WORDS; n++) begin
                roll = $urandom_range(99);
                if (roll < 60)
                    kind = KIND_TICK;
                else if (roll < 82)
                    kind = KIND_WRITE;
                else if (roll < 95)
                    kind = KIND_ACK;
                else
                    kind = KIND_START;
                queue_word(kind, 1'($urandom_range(1)), 9'($urandom_range(511)),
                           8'($urandom_range(255)));
            end
            wait_idle();
            steady <= 1'b0;
        end

        repeat (8) @(posedge i_clk);
        $display("Checked %0d results: %0d ticks, %0d loads, %0d writes, %0d starts, %0d acks.",
                 result_count, kind_count[KIND_TICK], load_count, kind_count[KIND_WRITE],
                 kind_count[KIND_START], kind_count[KIND_ACK]);
        $display("Playback swapped banks %0d times over %0d register settings; %0d mismatches.",
                 swap_count, setting_count, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/ppap_pkg.sv
hw/rtl/ppap_in_if.sv
hw/rtl/ppap_out_if.sv
hw/rtl/ppap_sample_ram.sv
hw/rtl/ppap_play_ctrl.sv
hw/rtl/ppap_duty_stage.sv
hw/rtl/ping_pong_pwm_audio_player_unit.sv
dv/tb_top.sv
